>>> design/affh_pkg.sv
`timescale 1ns / 1ps

package affh_pkg;

	localparam int RANGE_DEPTH_DEF = 16;
	localparam int SPACE_COUNT_DEF = 2;

	localparam int POS_W    = 21;
	localparam int CAND_W   = 23;
	localparam int ALIGN_W  = 13;
	localparam int CAP_W    = 20;
	localparam int OFF_W    = 20;
	localparam int REQ_W    = 20;
	localparam int BITS_W   = 23;
	localparam int STATUS_W = 3;
	localparam int STEP_W   = $clog2(CAND_W + 1);
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int BITS_PER_BYTE = 8;

	localparam logic [CAP_W-1:0]   CAP_VEC_RST = CAP_W'(2031616 / BITS_PER_BYTE);
	localparam logic [CAP_W-1:0]   CAP_MAT_RST = CAP_W'(4194304 / BITS_PER_BYTE);
	localparam logic [ALIGN_W-1:0] ALIGN_RST   = ALIGN_W'(256);

	localparam logic [1:0] REG_CAP_VEC = 2'd0;
	localparam logic [1:0] REG_CAP_MAT = 2'd1;
	localparam logic [1:0] REG_ALIGN   = 2'd2;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_ALLOC  = 2'd2;
	localparam logic [1:0] KIND_CHECK  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FIT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISALIGN = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVER_CAP = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [1:0]        kind;
		logic              space;
		logic [OFF_W-1:0]  offset_bytes;
		logic [BITS_W-1:0] occupied_bits;
		logic [REQ_W-1:0]  request_bytes;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    base;
	} out_item_t;

	typedef struct packed {
		logic               start;
		logic [CAND_W-1:0]  value;
		logic [ALIGN_W-1:0] align;
	} mod_req_t;

endpackage

>>> design/affh_range_mem.sv
`timescale 1ns / 1ps

module affh_range_mem #(
	parameter int AW = 5,
	parameter int DW = 42
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/affh_mod_unit.sv
`timescale 1ns / 1ps

module affh_mod_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  affh_pkg::mod_req_t            req,
	output logic                          done,
	output logic [affh_pkg::ALIGN_W-1:0]  rem
);

	logic                          busy_q;
	logic                          done_q;
	logic [affh_pkg::STEP_W-1:0]   step_q;
	logic [affh_pkg::CAND_W-1:0]   v_q;
	logic [affh_pkg::ALIGN_W-1:0]  rem_q;
	logic [affh_pkg::ALIGN_W-1:0]  a_q;
	logic [affh_pkg::ALIGN_W:0]    trial;
	logic [affh_pkg::ALIGN_W-1:0]  rem_nxt;

	// restoring remainder, one dividend bit a cycle
	always_comb begin
		trial = {rem_q, v_q[affh_pkg::CAND_W-1]};
		if (trial >= {1'b0, a_q}) begin
			rem_nxt = affh_pkg::ALIGN_W'(trial - {1'b0, a_q});
		end else begin
			rem_nxt = trial[affh_pkg::ALIGN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == affh_pkg::STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= affh_pkg::STEP_W'(affh_pkg::CAND_W);
			end else if (busy_q) begin
				step_q <= step_q - affh_pkg::STEP_W'(1);
				if (step_q == affh_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= (req.align == '0) ? affh_pkg::ALIGN_W'(1) : req.align;
			v_q   <= req.value;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			v_q   <= v_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("remainder unit did not start");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < a_q))
		else $error("remainder not below divisor");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("done while still busy");

endmodule

>>> design/affh_seq.sv
`timescale 1ns / 1ps

module affh_seq #(
	parameter int RANGE_DEPTH = affh_pkg::RANGE_DEPTH_DEF,
	parameter int SPACE_COUNT = affh_pkg::SPACE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  affh_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output affh_pkg::out_item_t           out_item,
	input  logic [affh_pkg::CAP_W-1:0]    cap_vec,
	input  logic [affh_pkg::CAP_W-1:0]    cap_mat,
	input  logic [affh_pkg::ALIGN_W-1:0]  align
);

	localparam int IW = $clog2(RANGE_DEPTH);
	localparam int CW = $clog2(RANGE_DEPTH + 1);
	localparam int TW = (SPACE_COUNT > 1) ? $clog2(SPACE_COUNT) : 1;
	localparam int AW = TW + IW;
	localparam int PW = affh_pkg::POS_W;
	localparam int XW = affh_pkg::CAND_W;
	localparam int BITS_W1 = affh_pkg::BITS_W + 1;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_A_ALIGN = 5'd1;
	localparam logic [4:0] S_A_MODW  = 5'd2;
	localparam logic [4:0] S_A_DATA  = 5'd3;
	localparam logic [4:0] S_A_FIN   = 5'd4;
	localparam logic [4:0] S_A_FMODW = 5'd5;
	localparam logic [4:0] S_A_CAP   = 5'd6;
	localparam logic [4:0] S_C_START = 5'd7;
	localparam logic [4:0] S_C_MODW  = 5'd8;
	localparam logic [4:0] S_I_START = 5'd9;
	localparam logic [4:0] S_P1_ADDR = 5'd10;
	localparam logic [4:0] S_P1_DATA = 5'd11;
	localparam logic [4:0] S_I_DEC   = 5'd12;
	localparam logic [4:0] S_SR_ADDR = 5'd13;
	localparam logic [4:0] S_SR_DATA = 5'd14;
	localparam logic [4:0] S_SL_ADDR = 5'd15;
	localparam logic [4:0] S_SL_DATA = 5'd16;
	localparam logic [4:0] S_WR_NEW  = 5'd17;
	localparam logic [4:0] S_DONE    = 5'd18;

	logic [4:0]                      state_q;
	logic [CW-1:0]                   cnt_q [SPACE_COUNT];
	logic                            out_valid_q;
	affh_pkg::out_item_t             out_item_q;
	logic                            s_q;
	logic [affh_pkg::OFF_W-1:0]      off_q;
	logic [affh_pkg::REQ_W-1:0]      req_q;
	logic [XW-1:0]                   cand_q;
	logic [PW-1:0]                   b_q, e_q, nb_q, ne_q;
	logic [CW-1:0]                   i_q, n_q, hits_q, p_q;
	logic                            alloc_q;
	logic [affh_pkg::STATUS_W-1:0]   res_status_q;
	logic [PW-1:0]                   res_base_q;

	logic                            has_tbl;
	logic [TW-1:0]                   tsel;
	logic [CW-1:0]                   n_cur;
	logic [affh_pkg::CAP_W-1:0]      cap_cur;
	logic [affh_pkg::ALIGN_W-1:0]    a_eff;
	affh_pkg::mod_req_t              mreq;
	logic                            mdone;
	logic [affh_pkg::ALIGN_W-1:0]    mrem;
	logic [XW-1:0]                   cand_up;
	logic [XW:0]                     cand_sum;
	logic [2*PW-1:0]                 rdata;
	logic [PW-1:0]                   rb, re;
	logic                            mem_we;
	logic [IW-1:0]                   widx;
	logic [2*PW-1:0]                 wdata;
	logic                            in_acc;
	logic                            out_load;
	logic [PW-1:0]                   rec_size;
	logic [affh_pkg::OFF_W:0]        chk_sum;

	assign has_tbl = (SPACE_COUNT > 1) || (s_q == 1'b0);
	assign tsel    = TW'(s_q);
	assign n_cur   = has_tbl ? cnt_q[tsel] : '0;
	assign cap_cur = !has_tbl ? '0 : (s_q ? cap_mat : cap_vec);
	assign a_eff   = (align == '0) ? affh_pkg::ALIGN_W'(1) : align;
	assign cand_up = (mrem == '0) ? cand_q
		: XW'(cand_q + XW'(a_eff) - XW'(mrem));
	assign cand_sum = {1'b0, cand_q} + (XW + 1)'(req_q);
	assign chk_sum  = {1'b0, off_q} + (affh_pkg::OFF_W + 1)'(req_q);
	assign rb = rdata[2*PW-1:PW];
	assign re = rdata[PW-1:0];
	assign rec_size = PW'(((BITS_W1'(in_item.occupied_bits)) + BITS_W1'(7)) >> 3);

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		mreq.start = (state_q == S_A_ALIGN) || (state_q == S_A_FIN) || (state_q == S_C_START);
		mreq.value = (state_q == S_C_START) ? XW'(off_q) : cand_q;
		mreq.align = align;
	end

	always_comb begin
		mem_we = 1'b0;
		widx   = p_q[IW-1:0];
		wdata  = {nb_q, ne_q};
		case (state_q)
			S_SR_DATA: begin
				mem_we = 1'b1;
				widx   = IW'(i_q + CW'(1));
				wdata  = rdata;
			end
			S_SL_DATA: begin
				mem_we = 1'b1;
				widx   = IW'(i_q - (hits_q - CW'(1)));
				wdata  = rdata;
			end
			S_WR_NEW: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	affh_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mdone),
		.rem    (mrem)
	);

	affh_range_mem #(
		.AW (AW),
		.DW (2 * PW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({tsel, widx}),
		.wdata (wdata),
		.raddr ({tsel, i_q[IW-1:0]}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			out_item_q   <= '0;
			for (int k = 0; k < SPACE_COUNT; k++) begin
				cnt_q[k] <= '0;
			end
			s_q          <= 1'b0;
			off_q        <= '0;
			req_q        <= '0;
			cand_q       <= '0;
			b_q          <= '0;
			e_q          <= '0;
			nb_q         <= '0;
			ne_q         <= '0;
			i_q          <= '0;
			n_q          <= '0;
			hits_q       <= '0;
			p_q          <= '0;
			alloc_q      <= 1'b0;
			res_status_q <= '0;
			res_base_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						s_q          <= in_item.space;
						off_q        <= in_item.offset_bytes;
						req_q        <= in_item.request_bytes;
						res_status_q <= affh_pkg::ST_OK;
						res_base_q   <= '0;
						alloc_q      <= 1'b0;
						case (in_item.kind)
							affh_pkg::KIND_CLEAR: begin
								for (int k = 0; k < SPACE_COUNT; k++) begin
									cnt_q[k] <= '0;
								end
								state_q <= S_DONE;
							end
							affh_pkg::KIND_RECORD: begin
								b_q     <= PW'(in_item.offset_bytes);
								e_q     <= PW'(PW'(in_item.offset_bytes) + rec_size);
								state_q <= S_I_START;
							end
							affh_pkg::KIND_ALLOC: begin
								cand_q  <= '0;
								i_q     <= '0;
								state_q <= S_A_FIN;
								if ((SPACE_COUNT > 1) || (in_item.space == 1'b0)) begin
									n_q <= cnt_q[TW'(in_item.space)];
									if (cnt_q[TW'(in_item.space)] != '0) begin
										state_q <= S_A_ALIGN;
									end
								end
							end
							default: begin
								state_q <= S_C_START;
							end
						endcase
					end
				end
				S_A_ALIGN: begin
					state_q <= S_A_MODW;
				end
				S_A_MODW: begin
					if (mdone) begin
						cand_q  <= cand_up;
						state_q <= S_A_DATA;
					end
				end
				S_A_DATA: begin
					if (cand_sum <= (XW + 1)'(rb)) begin
						state_q <= S_A_FIN;
					end else begin
						if (XW'(re) > cand_q) begin
							cand_q <= XW'(re);
						end
						if (i_q + CW'(1) == n_q) begin
							state_q <= S_A_FIN;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_A_ALIGN;
						end
					end
				end
				S_A_FIN: begin
					state_q <= S_A_FMODW;
				end
				S_A_FMODW: begin
					if (mdone) begin
						cand_q  <= cand_up;
						state_q <= S_A_CAP;
					end
				end
				S_A_CAP: begin
					if (!has_tbl || (cand_sum > (XW + 1)'(cap_cur))) begin
						res_status_q <= affh_pkg::ST_NO_FIT;
						state_q      <= S_DONE;
					end else begin
						b_q     <= cand_q[PW-1:0];
						e_q     <= cand_sum[PW-1:0];
						alloc_q <= 1'b1;
						state_q <= S_I_START;
					end
				end
				S_C_START: begin
					state_q <= S_C_MODW;
				end
				S_C_MODW: begin
					if (mdone) begin
						if (mrem != '0) begin
							res_status_q <= affh_pkg::ST_MISALIGN;
						end else if (chk_sum > (affh_pkg::OFF_W + 1)'(cap_cur)) begin
							res_status_q <= affh_pkg::ST_OVER_CAP;
						end
						state_q <= S_DONE;
					end
				end
				S_I_START: begin
					if (!has_tbl) begin
						res_status_q <= affh_pkg::ST_FULL;
						state_q      <= S_DONE;
					end else if (e_q <= b_q) begin
						res_base_q <= alloc_q ? cand_q[PW-1:0] : '0;
						state_q    <= S_DONE;
					end else begin
						n_q     <= n_cur;
						hits_q  <= '0;
						p_q     <= '0;
						nb_q    <= b_q;
						ne_q    <= e_q;
						i_q     <= '0;
						state_q <= (n_cur == '0) ? S_I_DEC : S_P1_ADDR;
					end
				end
				S_P1_ADDR: begin
					state_q <= S_P1_DATA;
				end
				S_P1_DATA: begin
					// overlapping or touching entries fold into the new range
					if ((rb <= e_q) && (b_q <= re)) begin
						hits_q <= hits_q + CW'(1);
						if (rb < nb_q) begin
							nb_q <= rb;
						end
						if (re > ne_q) begin
							ne_q <= re;
						end
					end else if (re < b_q) begin
						p_q <= p_q + CW'(1);
					end
					if (i_q + CW'(1) == n_q) begin
						state_q <= S_I_DEC;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_P1_ADDR;
					end
				end
				S_I_DEC: begin
					if ((hits_q == '0) && (n_q >= CW'(RANGE_DEPTH))) begin
						res_status_q <= affh_pkg::ST_FULL;
						state_q      <= S_DONE;
					end else if (hits_q == '0) begin
						if (n_q > p_q) begin
							i_q     <= n_q - CW'(1);
							state_q <= S_SR_ADDR;
						end else begin
							state_q <= S_WR_NEW;
						end
					end else if ((hits_q > CW'(1)) && ((p_q + hits_q) < n_q)) begin
						i_q     <= p_q + hits_q;
						state_q <= S_SL_ADDR;
					end else begin
						state_q <= S_WR_NEW;
					end
				end
				S_SR_ADDR: begin
					state_q <= S_SR_DATA;
				end
				S_SR_DATA: begin
					if (i_q == p_q) begin
						state_q <= S_WR_NEW;
					end else begin
						i_q     <= i_q - CW'(1);
						state_q <= S_SR_ADDR;
					end
				end
				S_SL_ADDR: begin
					state_q <= S_SL_DATA;
				end
				S_SL_DATA: begin
					if (i_q + CW'(1) == n_q) begin
						state_q <= S_WR_NEW;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_SL_ADDR;
					end
				end
				S_WR_NEW: begin
					cnt_q[tsel] <= CW'(n_q + CW'(1) - hits_q);
					res_base_q  <= alloc_q ? cand_q[PW-1:0] : '0;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_item_q.status <= res_status_q;
						out_item_q.base   <= res_base_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CW'(RANGE_DEPTH))
		else $error("range count beyond table depth");
	a_new_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR_NEW) |-> (p_q < CW'(RANGE_DEPTH)))
		else $error("merged range slot outside table");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stalled without an accepted item");

endmodule

>>> design/aligned_first_fit_hole_allocator.sv
`timescale 1ns / 1ps

// aligned first-fit hole allocator over local address spaces
// input channel in_valid/in_stall/in_item: one item per request (clear tables,
// record an occupied range, allocate a reserve region, check a manual base)
// output channel out_valid/out_stall/out_item: exactly one item (status, base)
// for every accepted input item, in order
// config over the apb port: capacity_vec at 0x0, capacity_mat at 0x4,
// align_bytes at 0x8; write only while the block is idle
// one item is worked at a time; in_stall stays high until its result sits in
// the output register. clear goes straight to the result; record reads each
// stored range and moves entries to make room or close gaps (an empty range
// writes nothing); check runs one remainder; allocate runs a remainder per
// range walked plus one for the final alignment and capacity test, then the
// record path, or ends on a miss. remainders come from the 23-step remainder
// unit, and each range entry is read through an address and a data state
// a finished result waits in the output register while out_stall is high, and
// the next input item is taken meanwhile; it finishes only once that slot frees
// reset empties every range table and loads default capacities and alignment;
// the range memory itself is not cleared
module aligned_first_fit_hole_allocator #(
	parameter int RANGE_DEPTH = affh_pkg::RANGE_DEPTH_DEF,
	parameter int SPACE_COUNT = affh_pkg::SPACE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  affh_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output affh_pkg::out_item_t           out_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [affh_pkg::PADDR_W-1:0]  paddr,
	input  logic [affh_pkg::PDATA_W-1:0]  pwdata,
	output logic [affh_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	logic [affh_pkg::CAP_W-1:0]   cap_vec_q;
	logic [affh_pkg::CAP_W-1:0]   cap_mat_q;
	logic [affh_pkg::ALIGN_W-1:0] align_q;
	logic                         wr_en;
	logic [1:0]                   reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_vec_q <= affh_pkg::CAP_VEC_RST;
			cap_mat_q <= affh_pkg::CAP_MAT_RST;
			align_q   <= affh_pkg::ALIGN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				affh_pkg::REG_CAP_VEC: cap_vec_q <= pwdata[affh_pkg::CAP_W-1:0];
				affh_pkg::REG_CAP_MAT: cap_mat_q <= pwdata[affh_pkg::CAP_W-1:0];
				affh_pkg::REG_ALIGN:   align_q   <= pwdata[affh_pkg::ALIGN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			affh_pkg::REG_CAP_VEC: prdata = affh_pkg::PDATA_W'(cap_vec_q);
			affh_pkg::REG_CAP_MAT: prdata = affh_pkg::PDATA_W'(cap_mat_q);
			affh_pkg::REG_ALIGN:   prdata = affh_pkg::PDATA_W'(align_q);
			default:               prdata = '0;
		endcase
	end

	affh_seq #(
		.RANGE_DEPTH (RANGE_DEPTH),
		.SPACE_COUNT (SPACE_COUNT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cap_vec   (cap_vec_q),
		.cap_mat   (cap_mat_q),
		.align     (align_q)
	);

endmodule
